FILE: src/hee_pkg.sv
`timescale 1ns / 1ps
// Package for the HTML entity escaper: byte codes, the output run type and
// the functions that turn one input byte into its run of output bytes.
// No dependencies.
package hee_pkg;

  // Longest run of output bytes one input byte can cause
  localparam int RUN_MAX   = 8;
  localparam int RUN_LEN_W = $clog2(RUN_MAX + 1);
  localparam int RUN_IDX_W = $clog2(RUN_MAX);

  // Byte codes
  localparam logic [7:0] LEAD_BYTE = 8'hC3;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QUOT   = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] FOL_AACUTE = 8'hA1;
  localparam logic [7:0] FOL_EACUTE = 8'hA9;
  localparam logic [7:0] FOL_IACUTE = 8'hAD;
  localparam logic [7:0] FOL_OACUTE = 8'hB3;
  localparam logic [7:0] FOL_UACUTE = 8'hBA;
  localparam logic [7:0] FOL_NTILDE = 8'hB1;
  localparam logic [7:0] FOL_NTILDE_UC = 8'h91;

  // A run of output bytes, first byte in slot 0
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [RUN_LEN_W-1:0]    len;
  } run_t;

  // Build a run from right-aligned text (first character highest)
  function automatic run_t mk_run(input logic [8*RUN_MAX-1:0] txt,
                                  input logic [RUN_LEN_W-1:0] n);
    run_t r;
    r     = '0;
    r.len = n;
    for (int k = 0; k < RUN_MAX; k++) begin
      if (k < int'(n)) begin
        r.bytes[k] = txt[8*(int'(n)-1-k) +: 8];
      end
    end
    return r;
  endfunction

  // Byte that follows a held lead byte and forms an accented letter
  function automatic logic is_accent(input logic [7:0] b);
    logic hit;
    case (b)
      FOL_AACUTE, FOL_EACUTE, FOL_IACUTE, FOL_OACUTE,
      FOL_UACUTE, FOL_NTILDE, FOL_NTILDE_UC: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic run_t accent_run(input logic [7:0] b);
    run_t r;
    case (b)
      FOL_AACUTE:    r = mk_run(64'("&aacute;"), RUN_LEN_W'(8));
      FOL_EACUTE:    r = mk_run(64'("&eacute;"), RUN_LEN_W'(8));
      FOL_IACUTE:    r = mk_run(64'("&iacute;"), RUN_LEN_W'(8));
      FOL_OACUTE:    r = mk_run(64'("&oacute;"), RUN_LEN_W'(8));
      FOL_UACUTE:    r = mk_run(64'("&uacute;"), RUN_LEN_W'(8));
      FOL_NTILDE:    r = mk_run(64'("&ntilde;"), RUN_LEN_W'(8));
      FOL_NTILDE_UC: r = mk_run(64'("&Ntilde;"), RUN_LEN_W'(8));
      default:       r = '0;
    endcase
    return r;
  endfunction

  // Lead byte that gets held back rather than emitted
  function automatic logic holds_lead(input logic [7:0] b, input logic last);
    return (b == LEAD_BYTE) && !last;
  endfunction

  // Run for a byte with nothing held
  function automatic run_t plain_run(input logic [7:0] b, input logic last);
    run_t r;
    case (b)
      CH_AMP:  r = mk_run(64'("&amp;"),  RUN_LEN_W'(5));
      CH_LT:   r = mk_run(64'("&lt;"),   RUN_LEN_W'(4));
      CH_GT:   r = mk_run(64'("&gt;"),   RUN_LEN_W'(4));
      CH_QUOT: r = mk_run(64'("&quot;"), RUN_LEN_W'(6));
      CH_APOS: r = mk_run(64'("&#39;"),  RUN_LEN_W'(5));
      default: begin
        if (holds_lead(b, last)) begin
          r = '0;
        end else begin
          r = mk_run({{(8*RUN_MAX-8){1'b0}}, b}, RUN_LEN_W'(1));
        end
      end
    endcase
    return r;
  endfunction

endpackage

FILE: src/hee_decode.sv
`timescale 1ns / 1ps
// Byte decoder: turns one input byte into its output run and tracks a
// held 0xC3 lead byte. Depends on hee_pkg.
module hee_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output hee_pkg::run_t run
);
  import hee_pkg::*;

  logic lead_held_r;
  logic lead_held_nxt;
  run_t plain;

  // Run for the new byte and the next held flag
  always_comb begin
    plain         = plain_run(in_byte, in_last);
    run           = plain;
    lead_held_nxt = holds_lead(in_byte, in_last);
    if (lead_held_r) begin
      if (is_accent(in_byte)) begin
        run           = accent_run(in_byte);
        lead_held_nxt = 1'b0;
      end else begin
        // held lead goes out first, then the byte as usual
        run.bytes = {plain.bytes[RUN_MAX-2:0], LEAD_BYTE};
        run.len   = plain.len + RUN_LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_held_r <= 1'b0;
    end else if (accept) begin
      lead_held_r <= lead_held_nxt;
    end
  end

endmodule

FILE: src/hee_emit.sv
`timescale 1ns / 1ps
// Run emitter: holds one decoded run and sends it a byte per transaction
// through an output register. Depends on hee_pkg.
module hee_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  hee_pkg::run_t run_in,
  output logic          can_load,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast
);
  import hee_pkg::*;

  logic [RUN_MAX-1:0][7:0] bytes_r;
  logic [RUN_LEN_W-1:0]    rem_r;
  logic [RUN_IDX_W-1:0]    pos_r;
  logic                    valid_r;
  logic [7:0]              byte_r;
  logic                    last_r;
  logic                    out_load;

  // Next byte moves to the output register when it is empty or being taken
  assign out_load = (rem_r != '0) && (!valid_r || out_tready);
  // A new run may enter once the current one has handed over its last byte
  assign can_load = (rem_r == '0) || ((rem_r == RUN_LEN_W'(1)) && out_load);

  // Run buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      pos_r <= '0;
    end else if (load) begin
      bytes_r <= run_in.bytes;
      rem_r   <= run_in.len;
      pos_r   <= '0;
    end else if (out_load) begin
      rem_r <= rem_r - RUN_LEN_W'(1);
      pos_r <= pos_r + RUN_IDX_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_load) begin
      valid_r <= 1'b1;
      byte_r  <= bytes_r[pos_r];
      last_r  <= (rem_r == RUN_LEN_W'(1));
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;

endmodule

FILE: src/html_entity_escape.sv
`timescale 1ns / 1ps
// Top level of the HTML entity escaper: byte decoder and run emitter.
// Depends on hee_pkg, hee_decode and hee_emit.
//
// Escapes a byte stream for HTML: & < > " ' become &amp; &lt; &gt; &quot;
// &#39;, and a 0xC3 lead byte followed by A1 A9 AD B3 BA B1 or 91 becomes
// the matching accented-letter entity (&aacute; ... &Ntilde;). A 0xC3 is
// held back until its follower arrives, or sent alone when in_tlast marks
// it as the end of the text. Each input transaction yields a run of 0 to 8
// output bytes, the last one flagged by out_tlast. An input byte holds the
// single run buffer until its last byte has gone to the output register,
// so plain text flows at one byte per cycle while the receiver is ready and
// an entity holds off input while its bytes go out; a held lead byte yields
// no output. The first output byte passes the run buffer, then the output
// register, which lets a new input enter while a byte waits.
module html_entity_escape (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // run_last
);
  import hee_pkg::*;

  logic accept;
  run_t run;

  assign accept = in_tvalid && in_tready;

  // Decode the incoming byte into a run
  hee_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .run     (run)
  );

  // Send the run out a byte at a time
  hee_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .run_in     (run),
    .can_load   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: src/hee_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the HTML entity escaper, bound to the top level.
// Depends on html_entity_escape.
module hee_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // Output register is empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A waiting input transaction keeps its payload until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tlast))
    else $error("stalled input changed");

  // A stalled output transaction holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  // Taking a byte that is not the end of its run brings the next one at once
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside an output run");

  // Input held off with an empty output register means a run is waiting
  a_pending_run: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !in_tready |=> out_tvalid)
    else $error("input stalled with nothing to send");

endmodule

bind html_entity_escape hee_checker u_hee_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for html_entity_escape: a directed table, then random text,
// checked byte by byte against an in-bench escaper. Depends on hee_pkg and the DUT.
module testbench;
  import hee_pkg::*;

  localparam int N_RANDOM   = 255;
  localparam int LONG_HOLD  = 80;
  localparam int CYCLE_CAP  = 200000;

  // One expected output byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } esc_byte_t;

  // One row of the directed table; txt is used only when typed is set
  typedef struct {
    logic [7:0] data;
    logic       eot;
    bit         typed;
    string      txt;
  } plan_row_t;

  localparam logic [7:0] ACCENT_FOL [7] = '{FOL_AACUTE, FOL_EACUTE, FOL_IACUTE, FOL_OACUTE,
                                            FOL_UACUTE, FOL_NTILDE, FOL_NTILDE_UC};
  localparam logic [7:0] SPECIAL_CH [5] = '{CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_byte
  logic       in_tlast = 1'b0;    // end_of_text
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic       out_tlast;          // run_last

  esc_byte_t  escaped_q[$];
  logic [7:0] run_bytes[$];
  logic       lead_pending = 1'b0;
  int         mismatches = 0;
  int         cycle_count = 0;
  bit         calm = 1'b0;
  bit         tx_quiet = 1'b0;
  bit         hold_req = 1'b0;
  plan_row_t  plan [25];

  html_entity_escape dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Escaper model --------------------------------------------------------

  function automatic void append_text(input string s);
    for (int k = 0; k < s.len(); k++) begin
      run_bytes.push_back(s[k]);
    end
  endfunction

  // Byte with no lead pending
  function automatic void escape_plain(input logic [7:0] b, input logic eot);
    case (b)
      CH_AMP:  append_text("&amp;");
      CH_LT:   append_text("&lt;");
      CH_GT:   append_text("&gt;");
      CH_QUOT: append_text("&quot;");
      CH_APOS: append_text("&#39;");
      default: begin
        if (b == LEAD_BYTE && !eot) begin
          lead_pending = 1'b1;
        end else begin
          run_bytes.push_back(b);
        end
      end
    endcase
  endfunction

  // Fills run_bytes with the output caused by one input transaction
  function automatic void predict_escape(input logic [7:0] b, input logic eot);
    run_bytes.delete();
    if (lead_pending) begin
      lead_pending = 1'b0;
      case (b)
        FOL_AACUTE:    append_text("&aacute;");
        FOL_EACUTE:    append_text("&eacute;");
        FOL_IACUTE:    append_text("&iacute;");
        FOL_OACUTE:    append_text("&oacute;");
        FOL_UACUTE:    append_text("&uacute;");
        FOL_NTILDE:    append_text("&ntilde;");
        FOL_NTILDE_UC: append_text("&Ntilde;");
        default: begin
          // unknown follower: lead goes out alone, follower escaped as usual
          run_bytes.push_back(LEAD_BYTE);
          escape_plain(b, eot);
        end
      endcase
    end else begin
      escape_plain(b, eot);
    end
  endfunction

  // Stimulus --------------------------------------------------------------

  // Offer one byte, wait for the transaction, then queue what it should yield
  task automatic send_byte(input logic [7:0] b, input logic eot,
                           input bit typed, input string txt);
    esc_byte_t e;
    if (!calm && !tx_quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    do @(posedge clk); while (!in_tready);
    predict_escape(b, eot);
    if (typed) begin
      run_bytes.delete();
      append_text(txt);
    end
    foreach (run_bytes[k]) begin
      e.data = run_bytes[k];
      e.last = (k == run_bytes.size() - 1);
      escaped_q.push_back(e);
    end
  endtask

  // Random text biased towards lead bytes, accents and special characters
  function automatic logic [7:0] pick_byte(input bit after_lead);
    int r;
    r = $urandom_range(0, 9);
    if (after_lead && r < 6) return ACCENT_FOL[$urandom_range(0, 6)];
    if (r < 3) return LEAD_BYTE;
    if (r < 4) return ACCENT_FOL[$urandom_range(0, 6)];
    if (r < 6) return SPECIAL_CH[$urandom_range(0, 4)];
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    logic [7:0] b;
    logic       eot;
    bit         after_lead;
    plan = '{
      '{8'h00,         1'b0, 1'b0, ""},
      '{8'hFF,         1'b0, 1'b0, ""},
      '{CH_AMP,        1'b0, 1'b1, "&amp;"},
      '{CH_LT,         1'b0, 1'b1, "&lt;"},
      '{CH_GT,         1'b0, 1'b1, "&gt;"},
      '{CH_QUOT,       1'b0, 1'b1, "&quot;"},
      '{CH_APOS,       1'b1, 1'b1, "&#39;"},
      '{LEAD_BYTE,     1'b1, 1'b0, ""},          // lead at end of text goes out alone
      '{LEAD_BYTE,     1'b0, 1'b1, ""},          // lead held, nothing out
      '{FOL_AACUTE,    1'b0, 1'b1, "&aacute;"},
      '{LEAD_BYTE,     1'b0, 1'b1, ""},
      '{FOL_EACUTE,    1'b0, 1'b1, "&eacute;"},
      '{LEAD_BYTE,     1'b0, 1'b1, ""},
      '{FOL_IACUTE,    1'b0, 1'b1, "&iacute;"},
      '{LEAD_BYTE,     1'b0, 1'b1, ""},
      '{FOL_OACUTE,    1'b0, 1'b1, "&oacute;"},
      '{LEAD_BYTE,     1'b0, 1'b1, ""},
      '{FOL_UACUTE,    1'b0, 1'b1, "&uacute;"},
      '{LEAD_BYTE,     1'b0, 1'b1, ""},
      '{FOL_NTILDE,    1'b0, 1'b1, "&ntilde;"},
      '{LEAD_BYTE,     1'b0, 1'b1, ""},
      '{FOL_NTILDE_UC, 1'b1, 1'b1, "&Ntilde;"},  // known follower with end of text
      '{LEAD_BYTE,     1'b0, 1'b0, ""},
      '{LEAD_BYTE,     1'b0, 1'b0, ""},          // lead after lead: first out, second held
      '{CH_AMP,        1'b1, 1'b0, ""}           // unknown follower escaped at end of text
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      send_byte(plan[i].data, plan[i].eot, plan[i].typed, plan[i].txt);
    end

    after_lead = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 32 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
      if (i == 120) hold_req = 1'b1;
      if (i == N_RANDOM - 40) calm = 1'b1;
      b   = pick_byte(after_lead);
      eot = ($urandom_range(0, 9) == 0);
      send_byte(b, eot, 1'b0, "");
      after_lead = lead_pending;
    end
    in_tvalid <= 1'b0;

    while (escaped_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS html_entity_escape");
    end else begin
      $display("FAIL html_entity_escape");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off while input keeps coming
  int  stall_left = 0;
  bit  rx_quiet = 1'b0;
  always @(posedge clk) begin
    if (cycle_count % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      stall_left = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (!calm && !rx_quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Checker: each output transaction against the oldest expected byte
  always @(posedge clk) begin
    esc_byte_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (escaped_q.size() == 0) begin
        $display("%0t: unexpected output byte %h last %b", $time, out_tdata, out_tlast);
        mismatches++;
      end else begin
        e = escaped_q.pop_front();
        if (out_tdata !== e.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, e.data, out_tdata);
          mismatches++;
        end
        if (out_tlast !== e.last) begin
          $display("%0t: run_last expected %b actual %b", $time, e.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("FAIL html_entity_escape");
      $finish;
    end
  end

endmodule
